// ===== hdl/acsm_pkg.sv =====
package acsm_pkg;

   // command codes
   localparam logic [2:0] CMD_ACTIVATE = 3'd0;
   localparam logic [2:0] CMD_REMOVE   = 3'd1;
   localparam logic [2:0] CMD_COMMIT   = 3'd2;
   localparam logic [2:0] CMD_HEAD     = 3'd3;
   localparam logic [2:0] CMD_NEXT     = 3'd4;

   // result status codes
   localparam logic [1:0] STS_DONE    = 2'd0;
   localparam logic [1:0] STS_NOCHG   = 2'd1;
   localparam logic [1:0] STS_REFUSED = 2'd2;
   localparam logic [1:0] STS_NONE    = 2'd3;

   // fixed field widths
   localparam int CMD_W   = 3;
   localparam int IDX_W   = 12;
   localparam int SEL_W   = 2;
   localparam int STS_W   = 2;
   localparam int LOUT_W  = 2;
   localparam int COUNT_W = 13;
   localparam int CSR_W   = 3;

endpackage

// ===== hdl/active_cell_set_manager_core.sv =====
// Active cell set manager: per-lane doubly linked lists of active cells.
// Request channel (req_valid / req_stall) carries command, cell index and
// lane select; a transaction is taken when req_valid is high and req_stall
// low. Each request yields exactly one response on rsp_valid / rsp_stall.
// Configuration channel (csr_valid / csr_ready) writes lanes_in_use; it is
// always ready and must only be used while no request is in flight.
// Requests are handled one at a time; all per-cell state lives in a single
// RAM with one read and one write port. Head queries, out-of-range indices
// and unknown commands go straight to the result; next, activate and remove
// read the cell first, and activate and remove may then update links;
// commit walks every lane and moves each pending cell, with an extra
// tail link update per cell appended behind an existing tail.
// After reset the per-cell RAM is swept once, every word cleared, with req_stall
// high; csr writes are taken during the sweep. A finished response sits in
// the output register while rsp_stall is high, and the next request is
// already accepted meanwhile; it then waits with its result until the
// output register frees.
module active_cell_set_manager_core
   import acsm_pkg::*;
#(
   parameter int CELLS = 4096,
   parameter int LANES = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [CMD_W-1:0]     req_command,
   input  logic [IDX_W-1:0]     req_cell_index,
   input  logic [SEL_W-1:0]     req_lane_select,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [STS_W-1:0]     rsp_status,
   output logic [LOUT_W-1:0]    rsp_lane_out,
   output logic [IDX_W-1:0]     rsp_cell_out,
   output logic [COUNT_W-1:0]   rsp_count_out,
   output logic [COUNT_W-1:0]   rsp_committed_total_out,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_W-1:0]     csr_lanes_in_use
);

   localparam int AW = $clog2(CELLS);
   localparam int CW = $clog2(CELLS + 1);
   localparam int LW = (LANES > 1) ? $clog2(LANES) : 1;
   localparam int XW = (CW > IDX_W) ? CW : IDX_W;
   localparam logic [CW-1:0] NIL = CW'(CELLS);

   typedef struct packed {
      logic          act;
      logic          pend;
      logic [LW-1:0] own;
      logic [CW-1:0] nxt;
      logic [CW-1:0] prv;
      logic [CW-1:0] plk;
   } cell_word_type;

   localparam int WW = $bits(cell_word_type);

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_READ, ST_LINK_PEND, ST_UNLINK_PREV, ST_UNLINK_NEXT,
      ST_COMMIT_LANE, ST_COMMIT_CELL, ST_COMMIT_TAIL, ST_DONE
   } state_type;

   state_type            state_ff, state_in;
   logic [AW-1:0]        clr_ff, clr_in;
   logic [CMD_W-1:0]     cmd_ff, cmd_in;
   logic [AW-1:0]        idx_ff, idx_in;
   logic [CW-1:0]        cur_ff, cur_in;
   logic [CW-1:0]        nx_ff, nx_in;
   logic [CW-1:0]        pv_ff, pv_in;
   logic [CW-1:0]        tail_ff, tail_in;
   logic [LW-1:0]        lane_ff, lane_in;
   logic [CW-1:0]        moved_ff, moved_in;
   logic [CW-1:0]        total_ff, total_in;
   logic [CSR_W-1:0]     lanes_ff, lanes_in;
   logic [CW-1:0]        lhead_ff [LANES], lhead_in [LANES];
   logic [CW-1:0]        ltail_ff [LANES], ltail_in [LANES];
   logic [CW-1:0]        phead_ff [LANES], phead_in [LANES];
   logic [CW-1:0]        ptail_ff [LANES], ptail_in [LANES];
   logic [CW-1:0]        lcount_ff [LANES], lcount_in [LANES];
   logic [STS_W-1:0]     res_status_ff, res_status_in;
   logic [LOUT_W-1:0]    res_lane_ff, res_lane_in;
   logic [IDX_W-1:0]     res_cell_ff, res_cell_in;
   logic [COUNT_W-1:0]   res_count_ff, res_count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [LOUT_W-1:0]    rsp_lane_ff, rsp_lane_in;
   logic [IDX_W-1:0]     rsp_cell_ff, rsp_cell_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;
   logic [COUNT_W-1:0]   rsp_total_ff, rsp_total_in;

   logic                 ram_we;
   logic [AW-1:0]        ram_wa;
   cell_word_type        ram_wd;
   logic [AW-1:0]        ram_ra;
   logic [WW-1:0]        ram_rd;
   cell_word_type        rword;

   logic [XW-1:0]        req_ext;
   logic                 req_in_range;
   logic [CSR_W-1:0]     eff_lanes;
   logic [LW-1:0]        pick;
   logic [CW:0]          total_sum;

   // per-cell state: flags, owner and the three links in one word
   acsm_ram #(
      .WIDTH (WW),
      .DEPTH (CELLS)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (ram_ra),
      .rd_data (ram_rd)
   );

   assign rword        = cell_word_type'(ram_rd);
   assign req_ext      = XW'(req_cell_index);
   assign req_in_range = req_ext < XW'(CELLS);
   assign req_stall    = state_ff != ST_IDLE;
   assign csr_ready    = 1'b1;
   assign total_sum    = {1'b0, total_ff} + {1'b0, moved_ff};

   // lanes register clamped to 1..LANES
   always_comb begin
      if (lanes_ff == '0) begin
         eff_lanes = CSR_W'(1);
      end else if (int'(lanes_ff) > LANES) begin
         eff_lanes = CSR_W'(LANES);
      end else begin
         eff_lanes = lanes_ff;
      end
   end

   // least-loaded lane, lowest index on ties
   always_comb begin
      pick = '0;
      for (int i = 1; i < LANES; i++) begin
         if (i < int'(eff_lanes) && lcount_ff[i] < lcount_ff[pick]) begin
            pick = LW'(i);
         end
      end
   end

   // sequencer next state and memory control
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      cmd_in        = cmd_ff;
      idx_in        = idx_ff;
      cur_in        = cur_ff;
      nx_in         = nx_ff;
      pv_in         = pv_ff;
      tail_in       = tail_ff;
      lane_in       = lane_ff;
      moved_in      = moved_ff;
      total_in      = total_ff;
      lanes_in      = lanes_ff;
      lhead_in      = lhead_ff;
      ltail_in      = ltail_ff;
      phead_in      = phead_ff;
      ptail_in      = ptail_ff;
      lcount_in     = lcount_ff;
      res_status_in = res_status_ff;
      res_lane_in   = res_lane_ff;
      res_cell_in   = res_cell_ff;
      res_count_in  = res_count_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_lane_in   = rsp_lane_ff;
      rsp_cell_in   = rsp_cell_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_total_in  = rsp_total_ff;
      ram_we        = 1'b0;
      ram_wa        = idx_ff;
      ram_wd        = rword;
      ram_ra        = idx_ff;

      if (csr_valid && csr_ready) begin
         lanes_in = csr_lanes_in_use;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            ram_we = 1'b1;
            ram_wa = clr_ff;
            ram_wd = '0;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_valid) begin
               cmd_in        = req_command;
               idx_in        = AW'(req_ext);
               ram_ra        = AW'(req_ext);
               res_status_in = STS_NOCHG;
               res_lane_in   = '0;
               res_cell_in   = '0;
               res_count_in  = '0;
               state_in      = ST_DONE;
               unique case (req_command) inside
                  CMD_ACTIVATE, CMD_REMOVE, CMD_NEXT: begin
                     if (req_in_range) begin
                        state_in = ST_READ;
                     end else if (req_command == CMD_NEXT) begin
                        res_status_in = STS_NONE;
                     end
                  end
                  CMD_COMMIT: begin
                     lane_in  = '0;
                     moved_in = '0;
                     state_in = ST_COMMIT_LANE;
                  end
                  CMD_HEAD: begin
                     res_status_in = STS_NONE;
                     if (int'(req_lane_select) < LANES) begin
                        res_lane_in  = req_lane_select;
                        res_count_in = COUNT_W'(lcount_ff[LW'(req_lane_select)]);
                        if (lhead_ff[LW'(req_lane_select)] < NIL) begin
                           res_status_in = STS_DONE;
                           res_cell_in   = IDX_W'(lhead_ff[LW'(req_lane_select)]);
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_READ: begin
            state_in = ST_DONE;
            case (cmd_ff)
               CMD_ACTIVATE: begin
                  if (rword.act) begin
                     res_lane_in  = LOUT_W'(rword.own);
                     res_count_in = COUNT_W'(lcount_ff[rword.own]);
                  end else begin
                     ram_we            = 1'b1;
                     ram_wd.act        = 1'b1;
                     ram_wd.pend       = 1'b1;
                     ram_wd.own        = pick;
                     ram_wd.plk        = NIL;
                     lcount_in[pick]   = lcount_ff[pick] + CW'(1);
                     res_status_in     = STS_DONE;
                     res_lane_in       = LOUT_W'(pick);
                     res_count_in      = COUNT_W'(lcount_ff[pick] + CW'(1));
                     ptail_in[pick]    = CW'(idx_ff);
                     tail_in           = ptail_ff[pick];
                     if (phead_ff[pick] < NIL && ptail_ff[pick] < NIL) begin
                        ram_ra   = AW'(ptail_ff[pick]);
                        state_in = ST_LINK_PEND;
                     end else begin
                        phead_in[pick] = CW'(idx_ff);
                     end
                  end
               end
               CMD_REMOVE: begin
                  if (rword.act) begin
                     res_lane_in  = LOUT_W'(rword.own);
                     res_count_in = COUNT_W'(lcount_ff[rword.own]);
                     if (rword.pend) begin
                        res_status_in = STS_REFUSED;
                     end else begin
                        ram_we        = 1'b1;
                        ram_wd.act    = 1'b0;
                        ram_wd.nxt    = NIL;
                        ram_wd.prv    = NIL;
                        res_status_in = STS_DONE;
                        if (lcount_ff[rword.own] != '0) begin
                           lcount_in[rword.own] = lcount_ff[rword.own] - CW'(1);
                           res_count_in = COUNT_W'(lcount_ff[rword.own] - CW'(1));
                        end
                        nx_in   = rword.nxt;
                        pv_in   = rword.prv;
                        lane_in = rword.own;
                        if (rword.prv < NIL) begin
                           ram_ra   = AW'(rword.prv);
                           state_in = ST_UNLINK_PREV;
                        end else begin
                           lhead_in[rword.own] = rword.nxt;
                           if (rword.nxt < NIL) begin
                              ram_ra   = AW'(rword.nxt);
                              state_in = ST_UNLINK_NEXT;
                           end else begin
                              ltail_in[rword.own] = rword.prv;
                           end
                        end
                     end
                  end
               end
               default: begin
                  // next query
                  res_status_in = STS_NONE;
                  if (rword.act && !rword.pend) begin
                     res_lane_in  = LOUT_W'(rword.own);
                     res_count_in = COUNT_W'(lcount_ff[rword.own]);
                     if (rword.nxt < NIL) begin
                        res_status_in = STS_DONE;
                        res_cell_in   = IDX_W'(rword.nxt);
                     end
                  end
               end
            endcase
         end

         ST_LINK_PEND: begin
            ram_we     = 1'b1;
            ram_wa     = AW'(tail_ff);
            ram_wd.plk = CW'(idx_ff);
            state_in   = ST_DONE;
         end

         ST_UNLINK_PREV: begin
            ram_we     = 1'b1;
            ram_wa     = AW'(pv_ff);
            ram_wd.nxt = nx_ff;
            state_in   = ST_DONE;
            if (nx_ff < NIL) begin
               ram_ra   = AW'(nx_ff);
               state_in = ST_UNLINK_NEXT;
            end else begin
               ltail_in[lane_ff] = pv_ff;
            end
         end

         ST_UNLINK_NEXT: begin
            ram_we     = 1'b1;
            ram_wa     = AW'(nx_ff);
            ram_wd.prv = pv_ff;
            state_in   = ST_DONE;
         end

         ST_COMMIT_LANE: begin
            if (phead_ff[lane_ff] < NIL) begin
               ram_ra   = AW'(phead_ff[lane_ff]);
               cur_in   = phead_ff[lane_ff];
               state_in = ST_COMMIT_CELL;
            end else if (lane_ff == LW'(LANES - 1)) begin
               if (total_sum > (CW + 1)'(CELLS)) begin
                  total_in = NIL;
               end else begin
                  total_in = CW'(total_sum);
               end
               res_status_in = (moved_ff != '0) ? STS_DONE : STS_NOCHG;
               res_lane_in   = '0;
               res_cell_in   = '0;
               res_count_in  = COUNT_W'(moved_ff);
               state_in      = ST_DONE;
            end else begin
               lane_in = lane_ff + LW'(1);
            end
         end

         ST_COMMIT_CELL: begin
            ram_we      = 1'b1;
            ram_wa      = AW'(cur_ff);
            ram_wd.pend = 1'b0;
            ram_wd.nxt  = NIL;
            ram_wd.prv  = NIL;
            moved_in    = moved_ff + CW'(1);
            nx_in       = rword.plk;
            tail_in     = ltail_ff[lane_ff];
            ltail_in[lane_ff] = cur_ff;
            if (lhead_ff[lane_ff] < NIL && ltail_ff[lane_ff] < NIL) begin
               ram_wd.prv = ltail_ff[lane_ff];
               ram_ra     = AW'(ltail_ff[lane_ff]);
               state_in   = ST_COMMIT_TAIL;
            end else begin
               lhead_in[lane_ff] = cur_ff;
               if (rword.plk < NIL) begin
                  ram_ra = AW'(rword.plk);
                  cur_in = rword.plk;
               end else begin
                  phead_in[lane_ff] = NIL;
                  ptail_in[lane_ff] = NIL;
                  state_in          = ST_COMMIT_LANE;
               end
            end
         end

         ST_COMMIT_TAIL: begin
            ram_we     = 1'b1;
            ram_wa     = AW'(tail_ff);
            ram_wd.nxt = cur_ff;
            if (nx_ff < NIL) begin
               ram_ra   = AW'(nx_ff);
               cur_in   = nx_ff;
               state_in = ST_COMMIT_CELL;
            end else begin
               phead_in[lane_ff] = NIL;
               ptail_in[lane_ff] = NIL;
               state_in          = ST_COMMIT_LANE;
            end
         end

         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_lane_in   = res_lane_ff;
               rsp_cell_in   = res_cell_ff;
               rsp_count_in  = res_count_ff;
               rsp_total_in  = COUNT_W'(total_ff);
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         total_ff     <= '0;
         lanes_ff     <= CSR_W'(4);
         for (int i = 0; i < LANES; i++) begin
            lhead_ff[i]  <= NIL;
            ltail_ff[i]  <= NIL;
            phead_ff[i]  <= NIL;
            ptail_ff[i]  <= NIL;
            lcount_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         total_ff     <= total_in;
         lanes_ff     <= lanes_in;
         lhead_ff     <= lhead_in;
         ltail_ff     <= ltail_in;
         phead_ff     <= phead_in;
         ptail_ff     <= ptail_in;
         lcount_ff    <= lcount_in;
      end
      cmd_ff        <= cmd_in;
      idx_ff        <= idx_in;
      cur_ff        <= cur_in;
      nx_ff         <= nx_in;
      pv_ff         <= pv_in;
      tail_ff       <= tail_in;
      lane_ff       <= lane_in;
      moved_ff      <= moved_in;
      res_status_ff <= res_status_in;
      res_lane_ff   <= res_lane_in;
      res_cell_ff   <= res_cell_in;
      res_count_ff  <= res_count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_lane_ff   <= rsp_lane_in;
      rsp_cell_ff   <= rsp_cell_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_total_ff  <= rsp_total_in;
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_status              = rsp_status_ff;
   assign rsp_lane_out            = rsp_lane_ff;
   assign rsp_cell_out            = rsp_cell_ff;
   assign rsp_count_out           = rsp_count_ff;
   assign rsp_committed_total_out = rsp_total_ff;

endmodule

// ===== hdl/acsm_ram.sv =====
module acsm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== hdl/acsm_checker.sv =====
module acsm_checker
   import acsm_pkg::*;
#(
   parameter int CELLS = 4096
) (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [STS_W-1:0]   rsp_status,
   input logic [IDX_W-1:0]   rsp_cell_out,
   input logic [COUNT_W-1:0] rsp_committed_total_out
);

   // stalled response transaction holds its status
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status))
      else $error("response changed while stalled");

   // only a successful query returns a cell
   a_cell_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STS_DONE |-> rsp_cell_out == '0)
      else $error("cell returned with non-done status");

   // running total saturates at the cell count
   a_total_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_committed_total_out <= COUNT_W'(CELLS))
      else $error("committed total above cell count");

   // no response and no request taken right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && req_stall)
      else $error("activity right after reset");

endmodule

bind active_cell_set_manager_core acsm_checker #(.CELLS(CELLS)) u_acsm_checker (
   .clock                   (clock),
   .reset                   (reset),
   .req_stall               (req_stall),
   .rsp_valid               (rsp_valid),
   .rsp_stall               (rsp_stall),
   .rsp_status              (rsp_status),
   .rsp_cell_out            (rsp_cell_out),
   .rsp_committed_total_out (rsp_committed_total_out)
);

// ===== verif/active_cell_set_manager_core_tb.sv =====
`timescale 1ns / 100ps

module active_cell_set_manager_core_tb;
   import acsm_pkg::*;

   localparam int NCELL = 4096;
   localparam int NLANE = 4;
   localparam int NULL_LINK = NCELL;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic [IDX_W-1:0] cell_idx;
      logic [SEL_W-1:0] sel;
   } cell_cmd_t;

   typedef struct packed {
      logic [STS_W-1:0]   status;
      logic [LOUT_W-1:0]  lane;
      logic [IDX_W-1:0]   cell_val;
      logic [COUNT_W-1:0] count;
      logic [COUNT_W-1:0] total;
   } cell_rsp_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [CMD_W-1:0] req_command = '0;
   logic [IDX_W-1:0] req_cell_index = '0;
   logic [SEL_W-1:0] req_lane_select = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [STS_W-1:0] rsp_status;
   logic [LOUT_W-1:0] rsp_lane_out;
   logic [IDX_W-1:0] rsp_cell_out;
   logic [COUNT_W-1:0] rsp_count_out;
   logic [COUNT_W-1:0] rsp_committed_total_out;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_W-1:0] csr_lanes_in_use = '0;

   active_cell_set_manager_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_command(req_command), .req_cell_index(req_cell_index),
      .req_lane_select(req_lane_select),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_lane_out(rsp_lane_out),
      .rsp_cell_out(rsp_cell_out), .rsp_count_out(rsp_count_out),
      .rsp_committed_total_out(rsp_committed_total_out),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_lanes_in_use(csr_lanes_in_use)
   );

   always #5 clock = ~clock;

   // shadow of the cell set
   bit          sh_active [NCELL];
   bit          sh_pending[NCELL];
   logic [1:0]  sh_owner  [NCELL];
   int unsigned sh_next   [NCELL];
   int unsigned sh_prev   [NCELL];
   int unsigned sh_plink  [NCELL];
   int unsigned sh_head[NLANE], sh_tail[NLANE], sh_phead[NLANE], sh_ptail[NLANE];
   int unsigned sh_count[NLANE];
   int unsigned sh_total;
   logic [2:0]  sh_lanes;

   cell_cmd_t pending_cmds[$];
   cell_rsp_t expected_rsps[$];
   int errors = 0;
   int accepted = 0;

   function automatic int unsigned least_loaded_lane();
      int unsigned n, best;
      n = 32'(sh_lanes);
      if (n == 0) n = 1;
      if (n > NLANE) n = NLANE;
      best = 0;
      for (int i = 1; i < n; i++)
         if (sh_count[i] < sh_count[best]) best = i;
      return best;
   endfunction

   function automatic void list_append(int unsigned ln, int unsigned c);
      sh_next[c] = NULL_LINK;
      if (sh_head[ln] >= NULL_LINK || sh_tail[ln] >= NULL_LINK) begin
         sh_head[ln] = c;
         sh_prev[c] = NULL_LINK;
      end else begin
         sh_next[sh_tail[ln]] = c;
         sh_prev[c] = sh_tail[ln];
      end
      sh_tail[ln] = c;
   endfunction

   // apply one transaction to the shadow and return the expected response
   function automatic cell_rsp_t apply_cell_cmd(cell_cmd_t t);
      cell_rsp_t r;
      int unsigned c, ln, moved, nx, pv;
      r = '0;
      r.status = STS_NOCHG;
      c = 32'(t.cell_idx);
      case (t.command)
         CMD_ACTIVATE: begin
            if (sh_active[c]) begin
               ln = 32'(sh_owner[c]);
               r.lane = 2'(ln);
               r.count = COUNT_W'(sh_count[ln]);
            end else begin
               ln = least_loaded_lane();
               sh_active[c] = 1;
               sh_pending[c] = 1;
               sh_owner[c] = 2'(ln);
               sh_count[ln]++;
               sh_plink[c] = NULL_LINK;
               if (sh_phead[ln] >= NULL_LINK || sh_ptail[ln] >= NULL_LINK)
                  sh_phead[ln] = c;
               else
                  sh_plink[sh_ptail[ln]] = c;
               sh_ptail[ln] = c;
               r.status = STS_DONE;
               r.lane = 2'(ln);
               r.count = COUNT_W'(sh_count[ln]);
            end
         end
         CMD_REMOVE: begin
            if (sh_active[c]) begin
               ln = 32'(sh_owner[c]);
               if (sh_pending[c]) begin
                  r.status = STS_REFUSED;
               end else begin
                  sh_active[c] = 0;
                  if (sh_count[ln] > 0) sh_count[ln]--;
                  nx = sh_next[c];
                  pv = sh_prev[c];
                  if (pv < NULL_LINK) sh_next[pv] = nx; else sh_head[ln] = nx;
                  if (nx < NULL_LINK) sh_prev[nx] = pv; else sh_tail[ln] = pv;
                  sh_next[c] = NULL_LINK;
                  sh_prev[c] = NULL_LINK;
                  r.status = STS_DONE;
               end
               r.lane = 2'(ln);
               r.count = COUNT_W'(sh_count[ln]);
            end
         end
         CMD_COMMIT: begin
            moved = 0;
            for (int l = 0; l < NLANE; l++) begin
               c = sh_phead[l];
               while (c < NULL_LINK) begin
                  nx = sh_plink[c];
                  sh_pending[c] = 0;
                  list_append(l, c);
                  moved++;
                  c = nx;
               end
               sh_phead[l] = NULL_LINK;
               sh_ptail[l] = NULL_LINK;
            end
            sh_total += moved;
            if (sh_total > NCELL) sh_total = NCELL;
            r.count = COUNT_W'(moved);
            r.status = (moved > 0) ? STS_DONE : STS_NOCHG;
         end
         CMD_HEAD: begin
            r.status = STS_NONE;
            r.lane = t.sel;
            r.count = COUNT_W'(sh_count[t.sel]);
            if (sh_head[t.sel] < NULL_LINK) begin
               r.status = STS_DONE;
               r.cell_val = IDX_W'(sh_head[t.sel]);
            end
         end
         CMD_NEXT: begin
            r.status = STS_NONE;
            if (sh_active[c] && !sh_pending[c]) begin
               ln = 32'(sh_owner[c]);
               r.lane = 2'(ln);
               r.count = COUNT_W'(sh_count[ln]);
               if (sh_next[c] < NULL_LINK) begin
                  r.status = STS_DONE;
                  r.cell_val = IDX_W'(sh_next[c]);
               end
            end
         end
         default: ;
      endcase
      r.total = COUNT_W'(sh_total);
      return r;
   endfunction

   // driver: bursts with random gaps
   int burst_left = 0;
   int gap_left = 0;
   bit drive_en = 0;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && req_stall) begin
         // hold the stalled transaction
      end else begin
         if (req_valid) begin
            accepted++;
            expected_rsps.push_back(apply_cell_cmd(pending_cmds.pop_front()));
         end
         if (gap_left > 0) gap_left--;
         if (drive_en && pending_cmds.size() > 0 && gap_left == 0) begin
            req_valid <= 1'b1;
            req_command <= pending_cmds[0].command;
            req_cell_index <= pending_cmds[0].cell_idx;
            req_lane_select <= pending_cmds[0].sel;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 20);
               if ($urandom_range(0, 2) == 0) gap_left = $urandom_range(1, 8);
            end else begin
               burst_left--;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall pattern, with one long hold-off
   int hold_cycles = 0;
   bit hold_req = 0;
   always @(posedge clock) begin
      if (hold_req && hold_cycles == 0) begin
         hold_cycles = 400;
         hold_req = 0;
      end
      if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_stall <= 1'b1;
      end else begin
         case ((accepted / 100) % 3)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 3) == 0);
            default: rsp_stall <= ($urandom_range(0, 1) == 0);
         endcase
      end
   end

   // monitor
   always @(posedge clock) begin
      cell_rsp_t got, exp_rsp;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_status, rsp_lane_out, rsp_cell_out, rsp_count_out,
                 rsp_committed_total_out};
         if (expected_rsps.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response %h", got);
         end else begin
            exp_rsp = expected_rsps.pop_front();
            if (got !== exp_rsp) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: exp sts=%0d lane=%0d cell=%0d cnt=%0d tot=%0d, got sts=%0d lane=%0d cell=%0d cnt=%0d tot=%0d",
                     exp_rsp.status, exp_rsp.lane, exp_rsp.cell_val, exp_rsp.count,
                     exp_rsp.total, got.status, got.lane, got.cell_val, got.count,
                     got.total);
            end
         end
      end
   end

   task automatic push_cmd(logic [2:0] cmd, int unsigned c, int unsigned s);
      cell_cmd_t t;
      t.command = cmd;
      t.cell_idx = IDX_W'(c);
      t.sel = SEL_W'(s);
      pending_cmds.push_back(t);
   endtask

   // wait for all stimulus to drain, then write lanes_in_use
   task automatic set_lanes(logic [2:0] n);
      drive_en = 1;
      while (pending_cmds.size() > 0 || expected_rsps.size() > 0 || req_valid)
         @(posedge clock);
      drive_en = 0;
      repeat (20) @(posedge clock);
      csr_valid <= 1'b1;
      csr_lanes_in_use <= n;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      sh_lanes = n;
      @(posedge clock);
   endtask

   // random phase: activates most often, mostly on a small pool, so lists grow and shrink
   task automatic random_phase(int n);
      int unsigned pick, c;
      for (int i = 0; i < n; i++) begin
         pick = $urandom_range(0, 99);
         c = ($urandom_range(0, 9) == 0) ? $urandom_range(0, NCELL - 1)
                                         : $urandom_range(0, 63);
         if (pick < 35) push_cmd(CMD_ACTIVATE, c, $urandom);
         else if (pick < 55) push_cmd(CMD_REMOVE, c, $urandom);
         else if (pick < 62) push_cmd(CMD_COMMIT, $urandom, $urandom);
         else if (pick < 72) push_cmd(CMD_HEAD, $urandom, $urandom);
         else if (pick < 95) push_cmd(CMD_NEXT, c, $urandom);
         else push_cmd(3'($urandom_range(5, 7)), $urandom, $urandom);
      end
   endtask

   initial begin
      for (int i = 0; i < NCELL; i++) begin
         sh_active[i] = 0; sh_pending[i] = 0; sh_owner[i] = 0;
         sh_next[i] = 0; sh_prev[i] = 0; sh_plink[i] = 0;
      end
      for (int l = 0; l < NLANE; l++) begin
         sh_head[l] = NULL_LINK; sh_tail[l] = NULL_LINK;
         sh_phead[l] = NULL_LINK; sh_ptail[l] = NULL_LINK; sh_count[l] = 0;
      end
      sh_total = 0;
      sh_lanes = 4;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: edges, refusals, walks, unknown commands
      push_cmd(CMD_HEAD, 0, 0);
      push_cmd(CMD_COMMIT, 0, 0);
      push_cmd(CMD_ACTIVATE, 0, 0);
      push_cmd(CMD_ACTIVATE, NCELL - 1, 3);
      push_cmd(CMD_ACTIVATE, 0, 0);
      push_cmd(CMD_REMOVE, 0, 0);
      push_cmd(CMD_NEXT, 0, 0);
      push_cmd(CMD_ACTIVATE, 12'h555, 1);
      push_cmd(CMD_ACTIVATE, 12'haaa, 2);
      push_cmd(CMD_ACTIVATE, 5, 0);
      push_cmd(CMD_ACTIVATE, 6, 0);
      push_cmd(CMD_COMMIT, 0, 0);
      push_cmd(CMD_HEAD, 0, 0);
      push_cmd(CMD_HEAD, 0, 3);
      push_cmd(CMD_NEXT, 0, 0);
      push_cmd(CMD_NEXT, 5, 0);
      push_cmd(CMD_REMOVE, 12'h555, 0);
      push_cmd(CMD_REMOVE, 7, 0);
      push_cmd(CMD_NEXT, 7, 0);
      push_cmd(3'd5, 12'hfff, 3);
      push_cmd(3'd7, 0, 0);
      set_lanes(3'd1);

      // random phases over register settings, zero and out-of-range included
      random_phase(150);
      set_lanes(3'd4);
      random_phase(150);
      set_lanes(3'd0);
      random_phase(150);
      set_lanes(3'd7);
      random_phase(100);
      set_lanes(3'd2);
      // long hold-off while the sender keeps pushing
      hold_req = 1;
      random_phase(200);
      set_lanes(3'd3);
      random_phase(200);
      drive_en = 1;
      while (pending_cmds.size() > 0 || expected_rsps.size() > 0 || req_valid)
         @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      #20ms;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
